@@ src/del_pkg.sv @@
// ---------------------------------------------------------------------------
// del_pkg: drum event looper shared definitions
// Widths, register reset values, configuration indexes, command, mode and ALU op codes, sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none

package del_pkg;

  // store geometry
  localparam int MAX_EVENTS = 256;
  localparam int TIME_WIDTH = 24;
  localparam int SAMPLE_W   = 8;
  localparam int IDX_W      = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int CNT_W      = $clog2(MAX_EVENTS + 1);
  localparam int ENTRY_W    = TIME_WIDTH + SAMPLE_W;

  // time arithmetic widths
  localparam int PLAY_W = TIME_WIDTH + 1;
  localparam int ALU_W  = TIME_WIDTH + 2;
  localparam int TICK_W = 16;

  // input and configuration widths
  localparam int CMD_W     = 2;
  localparam int DUR_W     = 24;
  localparam int HITS_W    = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = DUR_W;
  localparam int LIM_W     = (TIME_WIDTH > DUR_W) ? TIME_WIDTH : DUR_W;

  localparam logic [DUR_W-1:0]      DUR_RESET  = DUR_W'(1440000);
  localparam logic [HITS_W-1:0]     HITS_RESET = HITS_W'(64);
  localparam logic [HITS_W-1:0]     RESULT_CAP = HITS_W'(64);
  localparam logic [TIME_WIDTH-1:0] TIME_MAX   = {TIME_WIDTH{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUR  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HITS = CFG_IDX_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_SHORT = 2'd0,
    CMD_LONG  = 2'd1,
    CMD_HIT   = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    M_IDLE      = 4'b0001,
    M_ARMING    = 4'b0010,
    M_RECORDING = 4'b0100,
    M_PLAYING   = 4'b1000
  } mode_t;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_REC_ADD  = 8'b0000_0010,
    S_REC_CMP  = 8'b0000_0100,
    S_PLAY_ADD = 8'b0000_1000,
    S_PLAY_CMP = 8'b0001_0000,
    S_READ     = 8'b0010_0000,
    S_CHECK    = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

endpackage

`default_nettype wire

@@ src/drum_event_looper_top.sv @@
// ---------------------------------------------------------------------------
// drum_event_looper_top: drum hit recorder and looper
// Records timed drum hits into a store and replays them in tick windows.
//
//   channel   signals                                   direction  flow
//   command   start, busy, cmd, pad_id, tick_samples    in         start & !busy
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data in         valid & ready
//   result    strobe, hit_sample, last                  out        one cycle, no stall
//
// Presses and hits finish in the accept cycle; busy stays low.
// A recording tick passes through the shared adder in S_REC_ADD and S_REC_CMP.
// A playback tick adds and compares in S_PLAY_ADD and S_PLAY_CMP, then takes S_READ and
// S_CHECK for each stored hit examined, then S_DONE: each hit needs a store read and a compare.
// The final result, if any, appears in the cycle in which busy falls; results cannot be held off.
// rst is synchronous; the event store is not cleared, only entries below the count are read.
// ---------------------------------------------------------------------------
`default_nettype none

module drum_event_looper_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [del_pkg::CMD_W-1:0]       cmd,
  input  wire logic [del_pkg::SAMPLE_W-1:0]    pad_id,
  input  wire logic [del_pkg::TICK_W-1:0]      tick_samples,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [del_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [del_pkg::CFG_W-1:0]       cfg_data,
  output logic                                 strobe,
  output logic      [del_pkg::SAMPLE_W-1:0]    hit_sample,
  output logic                                 last
);

  import del_pkg::*;

  // control and looper state
  state_t                state;
  mode_t                 mode;
  logic [CNT_W-1:0]      event_count;
  logic [TIME_WIDTH-1:0] record_position;
  logic [PLAY_W-1:0]     play_position;
  logic [TIME_WIDTH-1:0] loop_length;
  logic [CNT_W-1:0]      play_index;
  logic [DUR_W-1:0]      max_dur;
  logic [HITS_W-1:0]     max_hits;

  // tick working registers
  logic [TICK_W-1:0]     tick_n;
  logic [ALU_W-1:0]      acc;
  logic [ALU_W-1:0]      win_lim;
  logic [ALU_W-1:0]      newpos;
  logic                  wrap;
  logic [HITS_W-1:0]     cap;
  logic [HITS_W-1:0]     hit_count;
  logic                  pend_valid;
  logic [SAMPLE_W-1:0]   pend_sample;

  logic                  accept;
  logic [TIME_WIDTH-1:0] rec_limit;
  logic [HITS_W-1:0]     cap_next;
  logic                  can_read;

  logic                  alu_op;
  logic [ALU_W-1:0]      alu_a;
  logic [ALU_W-1:0]      alu_b;
  logic [ALU_W-1:0]      alu_res;
  logic                  alu_borrow;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic                  ram_re;
  logic [ENTRY_W-1:0]    ram_rdata;
  logic [TIME_WIDTH-1:0] rd_time;
  logic [SAMPLE_W-1:0]   rd_sample;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign accept    = start && !busy;

  // effective limits from the configuration
  assign rec_limit = (LIM_W'(max_dur) > LIM_W'(TIME_MAX)) ? TIME_MAX : TIME_WIDTH'(max_dur);
  assign cap_next  = (max_hits > RESULT_CAP) ? RESULT_CAP : max_hits;
  assign can_read  = (play_index < event_count) && (hit_count < cap);

  // event store write on an accepted hit
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = event_count[IDX_W-1:0];
    ram_wdata = {record_position, pad_id};
    if (accept && cmd_t'(cmd) == CMD_HIT) begin
      if (mode == M_ARMING) begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {{TIME_WIDTH{1'b0}}, pad_id};
      end else if (mode == M_RECORDING && event_count < CNT_W'(MAX_EVENTS)) begin
        ram_we = 1'b1;
      end
    end
  end

  assign ram_re    = (state == S_READ);
  assign rd_time   = ram_rdata[ENTRY_W-1:SAMPLE_W];
  assign rd_sample = ram_rdata[SAMPLE_W-1:0];

  del_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_EVENTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (play_index[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // operand select for the shared adder
  always_comb begin
    unique case (state)
      S_REC_ADD: begin
        alu_op = ALU_ADD;
        alu_a  = ALU_W'(record_position);
        alu_b  = ALU_W'(tick_n);
      end
      S_REC_CMP: begin
        alu_op = ALU_SUB;
        alu_a  = acc;
        alu_b  = ALU_W'(rec_limit);
      end
      S_PLAY_ADD: begin
        alu_op = ALU_ADD;
        alu_a  = ALU_W'(play_position);
        alu_b  = ALU_W'(tick_n);
      end
      S_PLAY_CMP: begin
        alu_op = ALU_SUB;
        alu_a  = acc;
        alu_b  = ALU_W'(loop_length);
      end
      S_CHECK: begin
        alu_op = ALU_SUB;
        alu_a  = ALU_W'(rd_time);
        alu_b  = win_lim;
      end
      default: begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
      end
    endcase
  end

  del_alu u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  // sequencer and looper state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      mode            <= M_IDLE;
      event_count     <= '0;
      record_position <= '0;
      play_position   <= '0;
      loop_length     <= '0;
      play_index      <= '0;
      max_dur         <= DUR_RESET;
      max_hits        <= HITS_RESET;
      wrap            <= 1'b0;
      pend_valid      <= 1'b0;
      strobe          <= 1'b0;
    end else begin
      strobe <= 1'b0;

      // configuration writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MAX_DUR) begin
          max_dur <= cfg_data[DUR_W-1:0];
        end else if (cfg_index == CFG_MAX_HITS) begin
          max_hits <= cfg_data[HITS_W-1:0];
        end
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            tick_n <= tick_samples;
            unique case (cmd_t'(cmd))
              CMD_SHORT: begin
                unique case (mode)
                  M_IDLE:   mode <= M_ARMING;
                  M_ARMING: mode <= M_IDLE;
                  M_RECORDING: begin
                    if (record_position == '0) begin
                      mode            <= M_IDLE;
                      event_count     <= '0;
                      record_position <= '0;
                      play_position   <= '0;
                      loop_length     <= '0;
                      play_index      <= '0;
                    end else begin
                      loop_length   <= record_position;
                      play_position <= '0;
                      play_index    <= '0;
                      mode          <= M_PLAYING;
                    end
                  end
                  default: begin
                    mode            <= M_IDLE;
                    event_count     <= '0;
                    record_position <= '0;
                    play_position   <= '0;
                    loop_length     <= '0;
                    play_index      <= '0;
                  end
                endcase
              end
              CMD_LONG: begin
                mode            <= M_IDLE;
                event_count     <= '0;
                record_position <= '0;
                play_position   <= '0;
                loop_length     <= '0;
                play_index      <= '0;
              end
              CMD_HIT: begin
                if (mode == M_ARMING) begin
                  record_position <= '0;
                  event_count     <= CNT_W'(1);
                  mode            <= M_RECORDING;
                end else if (mode == M_RECORDING && event_count < CNT_W'(MAX_EVENTS)) begin
                  event_count <= event_count + CNT_W'(1);
                end
              end
              default: begin
                if (mode == M_RECORDING) begin
                  state <= S_REC_ADD;
                end else if (mode == M_PLAYING && loop_length != '0) begin
                  state      <= S_PLAY_ADD;
                  hit_count  <= '0;
                  cap        <= cap_next;
                  pend_valid <= 1'b0;
                end
              end
            endcase
          end
        end

        // recording tick: advance, then compare with the limit
        S_REC_ADD: begin
          acc   <= alu_res;
          state <= S_REC_CMP;
        end
        S_REC_CMP: begin
          state <= S_IDLE;
          if (!alu_borrow) begin
            if (rec_limit == '0) begin
              mode            <= M_IDLE;
              event_count     <= '0;
              record_position <= '0;
              play_position   <= '0;
              loop_length     <= '0;
              play_index      <= '0;
            end else begin
              record_position <= rec_limit;
              loop_length     <= rec_limit;
              play_position   <= '0;
              play_index      <= '0;
              mode            <= M_PLAYING;
            end
          end else begin
            record_position <= acc[TIME_WIDTH-1:0];
          end
        end

        // playback tick: window end, then wrap decision
        S_PLAY_ADD: begin
          acc   <= alu_res;
          state <= S_PLAY_CMP;
        end
        S_PLAY_CMP: begin
          state <= S_READ;
          if (alu_borrow) begin
            win_lim       <= acc;
            wrap          <= 1'b0;
            play_position <= acc[PLAY_W-1:0];
          end else begin
            win_lim       <= ALU_W'(loop_length);
            wrap          <= 1'b1;
            newpos        <= alu_res;
            play_position <= alu_res[PLAY_W-1:0];
          end
        end

        // fetch the next stored hit, restart from the first on a wrap, or end the pass
        S_READ: begin
          if (can_read) begin
            state <= S_CHECK;
          end else if (wrap) begin
            play_index <= '0;
            win_lim    <= newpos;
            wrap       <= 1'b0;
          end else begin
            state <= S_DONE;
          end
        end

        // hit inside the window: release the held item, hold this one; else wrap or end the pass
        S_CHECK: begin
          if (alu_borrow) begin
            if (pend_valid) begin
              strobe     <= 1'b1;
              hit_sample <= pend_sample;
              last       <= 1'b0;
            end
            pend_sample <= rd_sample;
            pend_valid  <= 1'b1;
            play_index  <= play_index + CNT_W'(1);
            hit_count   <= hit_count + HITS_W'(1);
            state       <= S_READ;
          end else if (wrap) begin
            play_index <= '0;
            win_lim    <= newpos;
            wrap       <= 1'b0;
            state      <= S_READ;
          end else begin
            state <= S_DONE;
          end
        end

        // flush the held item as the final one of the tick
        S_DONE: begin
          if (pend_valid) begin
            strobe     <= 1'b1;
            hit_sample <= pend_sample;
            last       <= 1'b1;
          end
          pend_valid <= 1'b0;
          state      <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/del_ram.sv @@
// ---------------------------------------------------------------------------
// del_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle, no reset on contents.
// ---------------------------------------------------------------------------
`default_nettype none

module del_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic                                        re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ src/del_alu.sv @@
// ---------------------------------------------------------------------------
// del_alu: shared time adder / comparator
// Adds two time values or subtracts them, the borrow giving a < b.
// ---------------------------------------------------------------------------
`default_nettype none

module del_alu (
  input  wire logic                     op,
  input  wire logic [del_pkg::ALU_W-1:0] a,
  input  wire logic [del_pkg::ALU_W-1:0] b,
  output logic      [del_pkg::ALU_W-1:0] res,
  output logic                          borrow
);

  import del_pkg::*;

  logic [ALU_W:0] wide;

  // one adder serves both operations
  always_comb begin
    if (alu_op_t'(op) == ALU_SUB) begin
      wide = {1'b0, a} - {1'b0, b};
    end else begin
      wide = {1'b0, a} + {1'b0, b};
    end
    res    = wide[ALU_W-1:0];
    borrow = (alu_op_t'(op) == ALU_SUB) ? wide[ALU_W] : 1'b0;
  end

endmodule

`default_nettype wire
